>>> rtl/core/sirt_pkg.sv
package sirt_pkg;

	localparam int ALEN_W      = 6;
	localparam int CFG_W       = 64;
	localparam int NUM_WORDS   = 4;
	localparam int ALPHA_CHARS = 32;
	localparam int ALPHA_BITS  = ALPHA_CHARS * 8;
	localparam int DIGIT_W     = 5;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [ALEN_W-1:0] LEN_RESET = 6'd10;
	localparam logic [CFG_W-1:0]  DIGITS_0_RESET = 64'h3736353433323130;
	localparam logic [CFG_W-1:0]  DIGITS_1_RESET = 64'h0000000000003938;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_ALPHABET_LENGTH = 3'd0;
	localparam reg_idx_t REG_DIGITS_0_TO_7   = 3'd1;
	localparam reg_idx_t REG_DIGITS_8_TO_15  = 3'd2;
	localparam reg_idx_t REG_DIGITS_16_TO_23 = 3'd3;
	localparam reg_idx_t REG_DIGITS_24_TO_31 = 3'd4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_DIV_INIT,
		OP_DIV,
		OP_STORE,
		OP_EMIT_MINUS,
		OP_EMIT_DIGIT,
		OP_EMIT_ZERO,
		OP_EMIT_ERR,
		OP_CHK_INIT,
		OP_CHK_STEP,
		OP_CHK_END
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_DIRTY,
		C_NO_INPUT,
		C_BAD_ALPHA,
		C_MAG_ZERO,
		C_MORE_CHUNKS,
		C_MAG_NONZERO,
		C_NOT_NEG,
		C_MORE_DIGITS,
		C_CHK_MORE
	} cond_t;

	typedef enum logic [3:0] {
		ST_DISPATCH,
		ST_WAIT,
		ST_CHECK_ALPHA,
		ST_CHECK_ZERO,
		ST_DIGIT,
		ST_DIV,
		ST_STORE,
		ST_SIGN,
		ST_MINUS,
		ST_EMIT,
		ST_RETURN,
		ST_ZERO,
		ST_ERR,
		ST_CHK_INIT,
		ST_CHK,
		ST_CHK_END
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// control store: jump to target when the condition holds, else fall through
	function automatic uword_t ucode(step_t s);
		uword_t w;
		case (s)
			ST_DISPATCH:    w = '{OP_NOP,        C_DIRTY,       ST_CHK_INIT};
			ST_WAIT:        w = '{OP_ACCEPT,     C_NO_INPUT,    ST_DISPATCH};
			ST_CHECK_ALPHA: w = '{OP_NOP,        C_BAD_ALPHA,   ST_ERR};
			ST_CHECK_ZERO:  w = '{OP_NOP,        C_MAG_ZERO,    ST_ZERO};
			ST_DIGIT:       w = '{OP_DIV_INIT,   C_NEVER,       ST_DISPATCH};
			ST_DIV:         w = '{OP_DIV,        C_MORE_CHUNKS, ST_DIV};
			ST_STORE:       w = '{OP_STORE,      C_MAG_NONZERO, ST_DIGIT};
			ST_SIGN:        w = '{OP_NOP,        C_NOT_NEG,     ST_EMIT};
			ST_MINUS:       w = '{OP_EMIT_MINUS, C_NEVER,       ST_DISPATCH};
			ST_EMIT:        w = '{OP_EMIT_DIGIT, C_MORE_DIGITS, ST_EMIT};
			ST_RETURN:      w = '{OP_NOP,        C_ALWAYS,      ST_DISPATCH};
			ST_ZERO:        w = '{OP_EMIT_ZERO,  C_ALWAYS,      ST_DISPATCH};
			ST_ERR:         w = '{OP_EMIT_ERR,   C_ALWAYS,      ST_DISPATCH};
			ST_CHK_INIT:    w = '{OP_CHK_INIT,   C_NEVER,       ST_DISPATCH};
			ST_CHK:         w = '{OP_CHK_STEP,   C_CHK_MORE,    ST_CHK};
			ST_CHK_END:     w = '{OP_CHK_END,    C_ALWAYS,      ST_DISPATCH};
			default:        w = '{OP_NOP,        C_ALWAYS,      ST_DISPATCH};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/sirt_ram.sv
module sirt_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/signed_integer_to_radix_text_top.sv
// Converts each signed VALUE_BITS-bit input value into text over a configurable digit
// alphabet of up to 32 characters, one character per output transaction: a '-' for a
// negative value, then the digits from the most significant, tlast on the final one;
// with a valid alphabet zero gives just '0', and a rejected alphabet (length below 2
// or above MAX_RADIX, a NUL, '+' or '-', or a repeated character) gives one transaction
// with data 0 and tuser 1. Control runs from a 16-step microcode table. After reset and
// after any configuration write the alphabet is validated once before the next input is
// taken. Every digit is one pass of a shared divider that consumes one byte of the dividend
// per cycle, and characters go out one per cycle, slower when the output side stalls.
module signed_integer_to_radix_text_top #(
	parameter int MAX_RADIX  = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // value
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [7:0]                             m_axis_tdata,  // character
	output logic                                   m_axis_tlast,
	output logic [0:0]                             m_axis_tuser,  // status
	input  logic                                   cfg_we,
	input  sirt_pkg::reg_idx_t                     cfg_index,
	input  logic [sirt_pkg::CFG_W-1:0]             cfg_data
);

	import sirt_pkg::*;

	localparam int CHUNKS = (VALUE_BITS + 7) / 8;
	localparam int PW     = CHUNKS * 8;
	localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int AW     = $clog2(VALUE_BITS);
	localparam int CNTW   = $clog2(VALUE_BITS + 1);

	function automatic logic [7:0] alpha_byte(logic [ALPHA_BITS-1:0] flat,
		logic [ALEN_W-1:0] pos);
		logic [7:0] b;
		b = CH_NUL;
		if (pos < ALEN_W'(ALPHA_CHARS)) begin
			b = flat[pos[DIGIT_W-1:0] * 8 +: 8];
		end
		return b;
	endfunction

	// one byte of long division; the remainder stays below the radix
	function automatic logic [8+DIGIT_W-1:0] div_byte(logic [DIGIT_W-1:0] r,
		logic [7:0] b, logic [ALEN_W-1:0] d);
		logic [ALEN_W-1:0]  acc;
		logic [7:0]         q;
		logic [DIGIT_W-1:0] rr;
		rr = r;
		q  = 8'h00;
		for (int k = 7; k >= 0; k--) begin
			acc = {rr, b[k]};
			if (acc >= d) begin
				acc  = acc - d;
				q[k] = 1'b1;
			end
			rr = acc[DIGIT_W-1:0];
		end
		return {q, rr};
	endfunction

	step_t  step_q, step_d;
	uword_t uw;
	logic   cond_hit, is_emit, hold, out_free, emit_fire;

	logic [ALEN_W-1:0]                len_q;
	logic [NUM_WORDS-1:0][CFG_W-1:0]  digits_q;
	logic [ALPHA_BITS-1:0]            alpha_flat;
	logic                             dirty_q, alpha_ok_q, bad_q, chk_bad;
	logic [ALEN_W-1:0]                chk_i_q;
	logic [7:0]                       chk_char;

	logic                 neg_q;
	logic [PW-1:0]        div_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [CHW-1:0]       chunk_q;
	logic [CNTW-1:0]      count_q, cnt_m1, cnt_m2;
	logic [VALUE_BITS-1:0] in_val, mag;
	logic [7:0]           quot_byte;
	logic [DIGIT_W-1:0]   rem_next;

	logic [AW-1:0]        rd_addr;
	logic [DIGIT_W-1:0]   rd_digit;

	logic       out_valid_q, out_last_q, out_status_q;
	logic [7:0] out_char_q;
	logic [7:0] emit_char;
	logic       emit_last, emit_status;

	assign alpha_flat = digits_q;
	assign uw         = ucode(step_q);
	assign in_val     = s_axis_tdata[VALUE_BITS-1:0];
	assign mag        = in_val[VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;
	assign {quot_byte, rem_next} = div_byte(rem_q, div_q[PW-1 -: 8], len_q);
	assign cnt_m1     = count_q - CNTW'(1);
	assign cnt_m2     = count_q - CNTW'(2);

	// duplicate and forbidden character test for the current position
	always_comb begin
		chk_char = alpha_byte(alpha_flat, chk_i_q);
		chk_bad  = (chk_char == CH_NUL) || (chk_char == CH_PLUS) || (chk_char == CH_MINUS);
		for (int j = 0; j < ALPHA_CHARS; j++) begin
			if ((ALEN_W'(j) > chk_i_q) && (ALEN_W'(j) < len_q)
				&& (alpha_flat[j*8 +: 8] == chk_char)) begin
				chk_bad = 1'b1;
			end
		end
	end

	always_comb begin
		case (uw.cond)
			C_NEVER:       cond_hit = 1'b0;
			C_ALWAYS:      cond_hit = 1'b1;
			C_DIRTY:       cond_hit = dirty_q;
			C_NO_INPUT:    cond_hit = !(s_axis_tvalid && s_axis_tready);
			C_BAD_ALPHA:   cond_hit = !alpha_ok_q;
			C_MAG_ZERO:    cond_hit = (div_q == '0);
			C_MORE_CHUNKS: cond_hit = (chunk_q != CHW'(CHUNKS - 1));
			C_MAG_NONZERO: cond_hit = (div_q != '0);
			C_NOT_NEG:     cond_hit = !neg_q;
			C_MORE_DIGITS: cond_hit = (count_q != CNTW'(1));
			C_CHK_MORE:    cond_hit = (chk_i_q < len_q);
			default:       cond_hit = 1'b0;
		endcase

		is_emit   = uw.op inside {OP_EMIT_MINUS, OP_EMIT_DIGIT, OP_EMIT_ZERO, OP_EMIT_ERR};
		out_free  = !out_valid_q || m_axis_tready;
		hold      = is_emit && !out_free;
		emit_fire = is_emit && out_free;

		if (hold) begin
			step_d = step_q;
		end else if (cond_hit) begin
			step_d = uw.target;
		end else begin
			step_d = step_t'(step_q + 4'd1);
		end

		case (uw.op)
			OP_EMIT_MINUS: begin
				emit_char = CH_MINUS; emit_last = 1'b0; emit_status = 1'b0;
			end
			OP_EMIT_DIGIT: begin
				emit_char   = alpha_byte(alpha_flat, {1'b0, rd_digit});
				emit_last   = (count_q == CNTW'(1));
				emit_status = 1'b0;
			end
			OP_EMIT_ZERO: begin
				emit_char = CH_ZERO; emit_last = 1'b1; emit_status = 1'b0;
			end
			OP_EMIT_ERR: begin
				emit_char = CH_NUL; emit_last = 1'b1; emit_status = 1'b1;
			end
			default: begin
				emit_char = CH_NUL; emit_last = 1'b0; emit_status = 1'b0;
			end
		endcase

		// registered read: fetch the next digit while the current one goes out
		if ((uw.op == OP_EMIT_DIGIT) && emit_fire) begin
			rd_addr = cnt_m2[AW-1:0];
		end else begin
			rd_addr = cnt_m1[AW-1:0];
		end
	end

	// no input while a fresh alphabet still waits for its check
	assign s_axis_tready = (uw.op == OP_ACCEPT) && !dirty_q && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_DISPATCH;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_RESET;
			digits_q[0] <= DIGITS_0_RESET;
			digits_q[1] <= DIGITS_1_RESET;
			digits_q[2] <= '0;
			digits_q[3] <= '0;
			dirty_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHABET_LENGTH: len_q       <= cfg_data[ALEN_W-1:0];
					REG_DIGITS_0_TO_7:   digits_q[0] <= cfg_data;
					REG_DIGITS_8_TO_15:  digits_q[1] <= cfg_data;
					REG_DIGITS_16_TO_23: digits_q[2] <= cfg_data;
					REG_DIGITS_24_TO_31: digits_q[3] <= cfg_data;
					default: ;
				endcase
			end
			// a write during validation forces another pass
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (uw.op == OP_CHK_INIT) begin
				dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_i_q    <= '0;
			bad_q      <= 1'b0;
			alpha_ok_q <= 1'b0;
			chunk_q    <= '0;
			count_q    <= '0;
		end else begin
			case (uw.op)
				OP_ACCEPT: begin
					if (s_axis_tvalid && s_axis_tready) begin
						count_q <= '0;
					end
				end
				OP_DIV_INIT: chunk_q <= '0;
				OP_DIV:      chunk_q <= chunk_q + 1'b1;
				OP_STORE:    count_q <= count_q + 1'b1;
				OP_EMIT_DIGIT: begin
					if (emit_fire) begin
						count_q <= cnt_m1;
					end
				end
				OP_CHK_INIT: begin
					chk_i_q <= '0;
					bad_q   <= (len_q < ALEN_W'(2)) || (int'(len_q) > MAX_RADIX);
				end
				OP_CHK_STEP: begin
					if (chk_i_q < len_q) begin
						bad_q   <= bad_q | chk_bad;
						chk_i_q <= chk_i_q + 1'b1;
					end
				end
				OP_CHK_END: alpha_ok_q <= !bad_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				if (s_axis_tvalid && s_axis_tready) begin
					neg_q <= in_val[VALUE_BITS-1];
					div_q <= PW'(mag);
				end
			end
			OP_DIV_INIT: rem_q <= '0;
			OP_DIV: begin
				div_q <= (div_q << 8) | PW'(quot_byte);
				rem_q <= rem_next;
			end
			default: ;
		endcase
	end

	sirt_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_digit_ram (
		.clk   (clk),
		.we    (uw.op == OP_STORE),
		.waddr (count_q[AW-1:0]),
		.wdata (rem_q),
		.raddr (rd_addr),
		.rdata (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_char_q   <= emit_char;
			out_last_q   <= emit_last;
			out_status_q <= emit_status;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_char_q;
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(VALUE_BITS))
		else $error("digit count beyond buffer depth");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (step_q == ST_CHECK_ALPHA))
		else $error("accepted transaction did not start a conversion");

	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_EMIT_DIGIT) |-> (count_q != '0))
		else $error("digit emitted with empty buffer");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == CH_NUL)))
		else $error("invalid alphabet result malformed");

endmodule

>>> dv/signed_integer_to_radix_text_top_test.sv
module signed_integer_to_radix_text_top_test;

	localparam int MAX_RADIX     = 32;
	localparam int VALUE_BITS    = 32;
	localparam int RANDOM_ITEMS  = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam sirt_pkg::reg_idx_t REG_NONE = 3'd7;

	typedef enum logic {
		STATUS_OK           = 1'b0,
		STATUS_INVALID_BASE = 1'b1
	} status_t;

	typedef enum int {
		CLEAN,
		HAS_NUL,
		HAS_PLUS_LAST,
		HAS_MINUS_LAST,
		HAS_SIGN,
		HAS_REPEAT
	} alpha_fault_t;

	typedef struct packed {
		logic [7:0] character;
		logic       is_last;
		status_t    status;
	} text_char_t;

	class radix_text_tracker;
		logic [sirt_pkg::ALEN_W-1:0] length;
		logic [sirt_pkg::CFG_W-1:0]  words [sirt_pkg::NUM_WORDS];
		text_char_t                  pending_text [$];
		int unsigned                 mismatches;

		function new();
			length     = sirt_pkg::LEN_RESET;
			words[0]   = sirt_pkg::DIGITS_0_RESET;
			words[1]   = sirt_pkg::DIGITS_1_RESET;
			words[2]   = '0;
			words[3]   = '0;
			mismatches = 0;
		endfunction

		function void write_reg(sirt_pkg::reg_idx_t idx, logic [sirt_pkg::CFG_W-1:0] data);
			case (idx)
				sirt_pkg::REG_ALPHABET_LENGTH: length = data[sirt_pkg::ALEN_W-1:0];
				sirt_pkg::REG_DIGITS_0_TO_7:   words[0] = data;
				sirt_pkg::REG_DIGITS_8_TO_15:  words[1] = data;
				sirt_pkg::REG_DIGITS_16_TO_23: words[2] = data;
				sirt_pkg::REG_DIGITS_24_TO_31: words[3] = data;
				default: ;
			endcase
		endfunction

		function logic [7:0] digit_char(int unsigned pos);
			return words[pos / 8][(pos % 8) * 8 +: 8];
		endfunction

		function bit alphabet_valid();
			logic [7:0] c;
			if (length < 2 || length > MAX_RADIX)
				return 0;
			for (int i = 0; i < length; i++) begin
				c = digit_char(i);
				if (c == sirt_pkg::CH_NUL || c == sirt_pkg::CH_PLUS || c == sirt_pkg::CH_MINUS)
					return 0;
				for (int j = i + 1; j < length; j++)
					if (digit_char(j) == c)
						return 0;
			end
			return 1;
		endfunction

		function void take_value(logic [VALUE_BITS-1:0] raw);
			logic [VALUE_BITS-1:0] mag;
			logic [VALUE_BITS-1:0] radix;
			logic [4:0]            digits [VALUE_BITS];
			int                    count;
			if (!alphabet_valid()) begin
				pending_text.push_back('{8'h00, 1'b1, STATUS_INVALID_BASE});
				return;
			end
			// magnitude taken unsigned so the most negative value converts exactly
			mag = raw[VALUE_BITS-1] ? -raw : raw;
			if (mag == 0) begin
				pending_text.push_back('{sirt_pkg::CH_ZERO, 1'b1, STATUS_OK});
				return;
			end
			radix = VALUE_BITS'(length);
			count = 0;
			while (mag != 0) begin
				digits[count] = 5'(mag % radix);
				mag = mag / radix;
				count++;
			end
			if (raw[VALUE_BITS-1])
				pending_text.push_back('{sirt_pkg::CH_MINUS, 1'b0, STATUS_OK});
			for (int i = count - 1; i >= 0; i--)
				pending_text.push_back('{digit_char(digits[i]), i == 0, STATUS_OK});
		endfunction

		function void match_char(logic [7:0] character, logic is_last, logic status);
			text_char_t want;
			if (pending_text.size() == 0) begin
				$error("unexpected transaction: character %02h last %0b status %0b",
					character, is_last, status);
				mismatches++;
				return;
			end
			want = pending_text.pop_front();
			if (character !== want.character) begin
				$error("character: expected %02h, got %02h", want.character, character);
				mismatches++;
			end
			if (is_last !== want.is_last) begin
				$error("last: expected %0b, got %0b", want.is_last, is_last);
				mismatches++;
			end
			if (status !== want.status) begin
				$error("status: expected %0b, got %0b", want.status, status);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_text.size();
		endfunction
	endclass

	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [31:0]                 s_axis_tdata  = '0;  // value
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [7:0]                  m_axis_tdata;        // character
	logic                        m_axis_tlast;
	logic [0:0]                  m_axis_tuser;        // status
	logic                        cfg_we        = 1'b0;
	sirt_pkg::reg_idx_t          cfg_index     = sirt_pkg::REG_ALPHABET_LENGTH;
	logic [sirt_pkg::CFG_W-1:0]  cfg_data      = '0;

	radix_text_tracker book = new();
	logic [7:0]        alpha [sirt_pkg::ALPHA_CHARS];
	bit                steady_source = 1'b0;
	bit                steady_sink   = 1'b0;
	int unsigned       sink_hold     = 0;
	int unsigned       sink_roll;

	signed_integer_to_radix_text_top #(
		.MAX_RADIX (MAX_RADIX),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check each transaction, then pick the next ready pattern
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			book.match_char(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (steady_sink) begin
			m_axis_tready <= 1'b1;
		end else begin
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 60) begin
				m_axis_tready <= 1'b1;
				sink_hold     <= $urandom_range(0, 8);
			end else if (sink_roll < 93) begin
				m_axis_tready <= 1'b0;
				sink_hold     <= $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b0;
				sink_hold     <= $urandom_range(4, 30);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] mag;
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			4, 5: mag = $urandom_range(0, 300);
			6: mag = $urandom_range(0, 70000);
			default: return $urandom;
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic logic [sirt_pkg::CFG_W-1:0] pack_word(int unsigned w);
		logic [sirt_pkg::CFG_W-1:0] word;
		for (int b = 0; b < 8; b++)
			word[b * 8 +: 8] = alpha[w * 8 + b];
		return word;
	endfunction

	task automatic write_cfg(input sirt_pkg::reg_idx_t idx, input logic [sirt_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		book.write_reg(idx, data);
	endtask

	task automatic program_alphabet(input logic [sirt_pkg::ALEN_W-1:0] len);
		logic [sirt_pkg::CFG_W-1:0] word;
		// junk above the length field must be dropped
		word = {$urandom, $urandom};
		word[sirt_pkg::ALEN_W-1:0] = len;
		write_cfg(sirt_pkg::REG_ALPHABET_LENGTH, word);
		write_cfg(sirt_pkg::REG_DIGITS_0_TO_7, pack_word(0));
		write_cfg(sirt_pkg::REG_DIGITS_8_TO_15, pack_word(1));
		write_cfg(sirt_pkg::REG_DIGITS_16_TO_23, pack_word(2));
		write_cfg(sirt_pkg::REG_DIGITS_24_TO_31, pack_word(3));
		if ($urandom_range(0, 3) == 0)
			write_cfg(REG_NONE, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	task automatic setup_alphabet(input logic [sirt_pkg::ALEN_W-1:0] len, input alpha_fault_t fault);
		bit          used [256];
		logic [7:0]  c;
		int unsigned pos;
		for (int i = 0; i < sirt_pkg::ALPHA_CHARS; i++) begin
			if (i < len) begin
				do
					c = 8'($urandom_range(1, 255));
				while (used[c] || c == sirt_pkg::CH_PLUS || c == sirt_pkg::CH_MINUS);
				used[c]  = 1'b1;
				alpha[i] = c;
			end else begin
				// unused positions may hold anything
				alpha[i] = 8'($urandom_range(0, 255));
			end
		end
		case (fault)
			HAS_NUL:        alpha[$urandom_range(0, len - 1)] = sirt_pkg::CH_NUL;
			HAS_PLUS_LAST:  alpha[len - 1] = sirt_pkg::CH_PLUS;
			HAS_MINUS_LAST: alpha[len - 1] = sirt_pkg::CH_MINUS;
			HAS_SIGN: begin
				alpha[$urandom_range(0, len - 1)] =
					$urandom_range(0, 1) ? sirt_pkg::CH_PLUS : sirt_pkg::CH_MINUS;
			end
			HAS_REPEAT: begin
				pos        = $urandom_range(1, len - 1);
				alpha[pos] = alpha[$urandom_range(0, pos - 1)];
			end
			default: ;
		endcase
		program_alphabet(len);
	endtask

	task automatic send_value(input logic [31:0] v);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do
			@(posedge clk);
		while (!s_axis_tready);
		book.take_value(v);
		gap = steady_source ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_text();
		s_axis_tvalid <= 1'b0;
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic try_rejected(input logic [sirt_pkg::ALEN_W-1:0] len, input alpha_fault_t fault,
			input logic [31:0] v);
		setup_alphabet(len, fault);
		send_value(v);
		wait_for_text();
	endtask

	initial begin
		logic [31:0] decimal_cases [7] = '{32'd0, 32'd1, 32'hffff_ffff, 32'd7,
			-32'd10, 32'h7fff_ffff, 32'h8000_0000};
		int unsigned random_sent;
		int unsigned count;
		int unsigned kind;
		logic [sirt_pkg::ALEN_W-1:0] len;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset alphabet is plain decimal
		foreach (decimal_cases[i])
			send_value(decimal_cases[i]);
		wait_for_text();

		// radix 2: the most negative value gives the longest text
		setup_alphabet(6'd2, CLEAN);
		send_value(32'd0);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		send_value(32'hffff_ffff);
		wait_for_text();

		setup_alphabet(6'd32, CLEAN);
		send_value(32'd31);
		send_value(-32'd32);
		send_value(32'h8000_0000);
		wait_for_text();

		try_rejected(6'd0, CLEAN, 32'd0);
		try_rejected(6'd1, CLEAN, 32'd5);
		try_rejected(6'd33, CLEAN, -32'd5);
		try_rejected(6'd63, CLEAN, 32'd12345);
		try_rejected(6'd10, HAS_NUL, 32'd1);
		try_rejected(6'd16, HAS_PLUS_LAST, 32'd2);
		try_rejected(6'd16, HAS_MINUS_LAST, -32'd3);
		try_rejected(6'd32, HAS_REPEAT, 32'd4);
		try_rejected(6'd8, HAS_SIGN, 32'd6);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				case ($urandom_range(0, 3))
					0: setup_alphabet(sirt_pkg::ALEN_W'($urandom_range(0, 1)), CLEAN);
					1: setup_alphabet(sirt_pkg::ALEN_W'($urandom_range(33, 63)), CLEAN);
					default: setup_alphabet(sirt_pkg::ALEN_W'($urandom_range(2, 32)),
						alpha_fault_t'($urandom_range(HAS_NUL, HAS_REPEAT)));
				endcase
				count = $urandom_range(3, 10);
			end else begin
				len = (kind == 1) ? 6'd2 : (kind == 2) ? 6'd32 :
					sirt_pkg::ALEN_W'($urandom_range(2, 32));
				setup_alphabet(len, CLEAN);
				count = $urandom_range(20, 60);
			end
			steady_source = ($urandom_range(0, 4) == 0);
			steady_sink  <= ($urandom_range(0, 4) == 0);
			repeat (count) begin
				send_value(pick_value());
				random_sent++;
			end
			wait_for_text();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
